// ===== sv/c93_pkg.sv =====
package c93_pkg;

	localparam int MaxLen     = 64;
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_DATA  = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	localparam logic [8:0] START_STOP = 9'h15E;
	localparam logic [8:0] TERM_BAR   = 9'h001;
	localparam logic [3:0] SYM_BITS   = 4'd9;
	localparam logic [3:0] TERM_BITS  = 4'd1;
	localparam logic [5:0] MOD_CHECK  = 6'd47;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_CHAR = 2'd1,
		ERR_MANY = 2'd2,
		ERR_FEW  = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		JOB_BEGIN = 2'd0,
		JOB_DATA  = 2'd1,
		JOB_END   = 2'd2,
		JOB_ERR   = 2'd3
	} job_kind_t;

	// one queued job; products are raw, reduced mod 47 in the back end
	typedef struct packed {
		job_kind_t   kind;
		err_t        err;
		logic [5:0]  value;
		logic [9:0]  c_prod;
		logic [9:0]  k_prod;
		logic [9:0]  width;
	} job_t;

	function automatic logic [8:0] symbol_pattern(input logic [5:0] v);
		logic [8:0] p;
		case (v)
			6'd0:  p = 9'h114;
			6'd1:  p = 9'h148;
			6'd2:  p = 9'h144;
			6'd3:  p = 9'h142;
			6'd4:  p = 9'h128;
			6'd5:  p = 9'h124;
			6'd6:  p = 9'h122;
			6'd7:  p = 9'h150;
			6'd8:  p = 9'h112;
			6'd9:  p = 9'h10A;
			6'd10: p = 9'h1A8;
			6'd11: p = 9'h1A4;
			6'd12: p = 9'h1A2;
			6'd13: p = 9'h194;
			6'd14: p = 9'h192;
			6'd15: p = 9'h18A;
			6'd16: p = 9'h168;
			6'd17: p = 9'h164;
			6'd18: p = 9'h162;
			6'd19: p = 9'h134;
			6'd20: p = 9'h11A;
			6'd21: p = 9'h158;
			6'd22: p = 9'h14C;
			6'd23: p = 9'h146;
			6'd24: p = 9'h12C;
			6'd25: p = 9'h116;
			6'd26: p = 9'h1B4;
			6'd27: p = 9'h1B2;
			6'd28: p = 9'h1AC;
			6'd29: p = 9'h1A6;
			6'd30: p = 9'h196;
			6'd31: p = 9'h19A;
			6'd32: p = 9'h16C;
			6'd33: p = 9'h166;
			6'd34: p = 9'h136;
			6'd35: p = 9'h13A;
			6'd36: p = 9'h12E;
			6'd37: p = 9'h1D4;
			6'd38: p = 9'h1D2;
			6'd39: p = 9'h1CA;
			6'd40: p = 9'h16E;
			6'd41: p = 9'h176;
			6'd42: p = 9'h1AE;
			6'd43: p = 9'h126;
			6'd44: p = 9'h1DA;
			6'd45: p = 9'h1D6;
			6'd46: p = 9'h132;
			default: p = 9'h000;
		endcase
		return p;
	endfunction

endpackage

// ===== sv/c93_front.sv =====
module c93_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    cmd,
	input  logic [7:0]    char_code,
	input  logic [6:0]    msg_length,
	input  logic          q_full,
	output logic          q_push,
	output c93_pkg::job_t q_job
);
	import c93_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_ACTIVE = 3'b010,
		PH_DROP   = 3'b100
	} phase_t;

	phase_t      phase_q;
	logic [4:0]  c_weight_q;
	logic [3:0]  k_weight_q;
	logic [6:0]  remain_q;
	logic [9:0]  width_q;

	// bit 6 flags a member of the character set
	function automatic logic [6:0] char_value(input logic [7:0] ch);
		logic [6:0] r;
		case (ch) inside
			[8'h30:8'h39]: r = {1'b1, 6'(ch - 8'h30)};
			[8'h41:8'h5A]: r = {1'b1, 6'(ch - 8'h37)};
			8'h2D:         r = {1'b1, 6'd36};
			8'h2E:         r = {1'b1, 6'd37};
			8'h20:         r = {1'b1, 6'd38};
			8'h24:         r = {1'b1, 6'd39};
			8'h2F:         r = {1'b1, 6'd40};
			8'h2B:         r = {1'b1, 6'd41};
			8'h25:         r = {1'b1, 6'd42};
			default:       r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] mod20(input logic [6:0] x);
		logic [6:0] r;
		r = x;
		if (r >= 7'd80) r = r - 7'd80;
		if (r >= 7'd40) r = r - 7'd40;
		if (r >= 7'd20) r = r - 7'd20;
		return r[4:0];
	endfunction

	function automatic logic [3:0] mod15(input logic [6:0] x);
		logic [6:0] r;
		r = x;
		if (r >= 7'd120) r = r - 7'd120;
		if (r >= 7'd60) r = r - 7'd60;
		if (r >= 7'd30) r = r - 7'd30;
		if (r >= 7'd15) r = r - 7'd15;
		return r[3:0];
	endfunction

	logic        accept;
	logic [6:0]  lookup;
	logic [10:0] width_raw;
	logic [9:0]  width_new;
	logic [9:0]  c_full;
	logic [9:0]  k_full;
	logic        too_long;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign lookup    = char_value(char_code);
	assign width_raw = {4'd0, msg_length} * 11'd9 + 11'd37;
	assign width_new = (width_raw > 11'd1023) ? 10'd1023 : width_raw[9:0];
	// largest product is 42 * 20, well inside 10 bits
	assign c_full    = {4'd0, lookup[5:0]} * {5'd0, c_weight_q};
	assign k_full    = {4'd0, lookup[5:0]} * {6'd0, k_weight_q};
	assign too_long  = {1'b0, msg_length} > 8'(MaxLen);

	always_comb begin
		q_push       = 1'b0;
		q_job.kind   = JOB_DATA;
		q_job.err    = ERR_NONE;
		q_job.value  = lookup[5:0];
		q_job.c_prod = c_full;
		q_job.k_prod = k_full;
		q_job.width  = width_q;
		if (accept) begin
			case (cmd)
				CMD_BEGIN: begin
					q_push      = 1'b1;
					q_job.width = width_new;
					if (too_long) begin
						q_job.kind = JOB_ERR;
						q_job.err  = ERR_MANY;
					end else begin
						q_job.kind = JOB_BEGIN;
					end
				end
				CMD_DATA: begin
					if (phase_q == PH_ACTIVE) begin
						q_push = 1'b1;
						if (remain_q == 7'd0) begin
							q_job.kind = JOB_ERR;
							q_job.err  = ERR_MANY;
						end else if (!lookup[6]) begin
							q_job.kind = JOB_ERR;
							q_job.err  = ERR_CHAR;
						end
					end
				end
				CMD_END: begin
					if (phase_q == PH_ACTIVE) begin
						q_push = 1'b1;
						if (remain_q != 7'd0) begin
							q_job.kind = JOB_ERR;
							q_job.err  = ERR_FEW;
						end else begin
							q_job.kind = JOB_END;
						end
					end
				end
				default: q_push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			c_weight_q <= 5'd1;
			k_weight_q <= 4'd1;
			remain_q   <= 7'd0;
			width_q    <= 10'd37;
		end else if (accept) begin
			if (cmd == CMD_BEGIN) begin
				width_q  <= width_new;
				remain_q <= msg_length;
				if (msg_length == 7'd0) begin
					c_weight_q <= 5'd1;
					k_weight_q <= 4'd1;
				end else begin
					c_weight_q <= mod20(msg_length - 7'd1) + 5'd1;
					k_weight_q <= mod15(msg_length) + 4'd1;
				end
				phase_q <= too_long ? PH_DROP : PH_ACTIVE;
			end else if (q_push) begin
				if (q_job.kind == JOB_ERR) begin
					phase_q <= PH_DROP;
				end else if (q_job.kind == JOB_END) begin
					phase_q <= PH_IDLE;
				end else begin
					c_weight_q <= (c_weight_q <= 5'd1) ? 5'd20 : c_weight_q - 5'd1;
					k_weight_q <= (k_weight_q <= 4'd1) ? 4'd15 : k_weight_q - 4'd1;
					remain_q   <= remain_q - 7'd1;
				end
			end
		end
	end

endmodule

// ===== sv/c93_fifo.sv =====
module c93_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  c93_pkg::job_t wr_job,
	input  logic          pop,
	output c93_pkg::job_t rd_job,
	output logic          not_empty,
	output logic          full
);
	import c93_pkg::*;

	job_t             slot_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign rd_job    = slot_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == QCntW'(QueueDepth);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCntW'(1);
				2'b01:   count_q <= count_q - QCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/c93_back.sv =====
module c93_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  c93_pkg::job_t q_job,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [8:0]    pattern,
	output logic [3:0]    bit_count,
	output logic [1:0]    error_code,
	output logic [9:0]    total_width,
	output logic          last
);
	import c93_pkg::*;

	// trailing results of an end job
	typedef enum logic [3:0] {
		BK_RUN  = 4'b0001,
		BK_K    = 4'b0010,
		BK_STOP = 4'b0100,
		BK_TERM = 4'b1000
	} back_state_t;

	function automatic logic [5:0] mod47(input logic [9:0] x);
		logic [9:0] r;
		r = x;
		if (r >= 10'd752) r = r - 10'd752;
		if (r >= 10'd376) r = r - 10'd376;
		if (r >= 10'd188) r = r - 10'd188;
		if (r >= 10'd94) r = r - 10'd94;
		if (r >= 10'd47) r = r - 10'd47;
		return r[5:0];
	endfunction

	function automatic logic [5:0] add47(input logic [5:0] a, input logic [5:0] b);
		logic [6:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, MOD_CHECK}) s = s - {1'b0, MOD_CHECK};
		return s[5:0];
	endfunction

	back_state_t state_q;
	logic [5:0]  csum_q;
	logic [5:0]  ksum_q;
	logic [5:0]  kval_q;
	logic        out_valid_q;
	logic [8:0]  pattern_q;
	logic [3:0]  count_q;
	err_t        err_q;
	logic [9:0]  width_q;
	logic        last_q;

	logic        out_free;
	logic [5:0]  csum_next;
	logic [5:0]  ksum_next;

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = q_valid && out_free && (state_q == BK_RUN);
	assign csum_next = add47(csum_q, mod47(q_job.c_prod));
	assign ksum_next = add47(ksum_q, mod47(q_job.k_prod));

	assign out_valid   = out_valid_q;
	assign pattern     = pattern_q;
	assign bit_count   = count_q;
	assign error_code  = err_q;
	assign total_width = width_q;
	assign last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			out_valid_q <= 1'b0;
			csum_q      <= 6'd0;
			ksum_q      <= 6'd0;
		end else if (out_free) begin
			case (state_q)
				BK_RUN: begin
					out_valid_q <= q_valid;
					if (q_valid) begin
						case (q_job.kind)
							JOB_DATA: begin
								csum_q <= csum_next;
								ksum_q <= ksum_next;
							end
							JOB_END: state_q <= BK_K;
							default: begin
								csum_q <= 6'd0;
								ksum_q <= 6'd0;
							end
						endcase
					end
				end
				BK_K:    state_q <= BK_STOP;
				BK_STOP: state_q <= BK_TERM;
				BK_TERM: state_q <= BK_RUN;
				default: state_q <= BK_RUN;
			endcase
		end
	end

	// result payload; width holds across the trailing results of an end job
	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				BK_RUN: begin
					if (q_valid) begin
						width_q <= q_job.width;
						count_q <= SYM_BITS;
						err_q   <= ERR_NONE;
						last_q  <= 1'b0;
						case (q_job.kind)
							JOB_BEGIN: pattern_q <= START_STOP;
							JOB_DATA:  pattern_q <= symbol_pattern(q_job.value);
							JOB_END: begin
								pattern_q <= symbol_pattern(csum_q);
								kval_q    <= add47(ksum_q, csum_q);
							end
							default: begin
								pattern_q <= 9'd0;
								count_q   <= 4'd0;
								err_q     <= q_job.err;
								last_q    <= 1'b1;
							end
						endcase
					end
				end
				BK_K: pattern_q <= symbol_pattern(kval_q);
				BK_STOP: pattern_q <= START_STOP;
				BK_TERM: begin
					pattern_q <= TERM_BAR;
					count_q   <= TERM_BITS;
					last_q    <= 1'b1;
				end
				default: pattern_q <= pattern_q;
			endcase
		end
	end

endmodule

// ===== sv/code93_barcode_encoder.sv =====
// Code 93 encoder with C and K check characters. Send a begin item (cmd 0)
// with the message length, one data item (cmd 1) per character, then an end
// item (cmd 2). Each begin or data item yields one 9-module pattern, the end
// item yields four results (C, K, stop, 1-module termination bar with last
// set); an error yields a single result with last set and items up to the
// next begin are discarded. One item is taken per clock unless the queue is
// full: the front end classifies it and computes the check products in the
// same cycle, a 4-entry job queue follows, and the back end reduces the sums
// mod 47 and emits one result per clock from its output register while the
// output is not stalled. An end item holds the back end in its K, stop and
// termination states, which the queue absorbs; input stalls only when it is full.
module code93_barcode_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic [6:0] msg_length,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [8:0] pattern,
	output logic [3:0] bit_count,
	output logic [1:0] error_code,
	output logic [9:0] total_width,
	output logic       last
);
	import c93_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	job_t push_job;
	job_t head_job;

	c93_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.msg_length (msg_length),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	c93_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_job    (push_job),
		.pop       (q_pop),
		.rd_job    (head_job),
		.not_empty (q_valid),
		.full      (q_full)
	);

	c93_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_job       (head_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pattern     (pattern),
		.bit_count   (bit_count),
		.error_code  (error_code),
		.total_width (total_width),
		.last        (last)
	);

`ifndef ASSERT_OFF
	a_stall_needs_jobs: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_valid)
		else $error("input stalled with an empty job queue");

	a_last_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> (bit_count == TERM_BITS && error_code == ERR_NONE) ||
			(bit_count == 4'd0 && error_code != ERR_NONE))
		else $error("last result is neither termination bar nor error");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> last && pattern == 9'd0)
		else $error("error result malformed");

	a_width_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> total_width >= 10'd37)
		else $error("total width below empty message width");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import c93_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int TARGET_ITEMS = 400;
	localparam int QUIET_TAIL   = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 150;
	localparam int C_SPAN       = 20;
	localparam int K_SPAN       = 15;
	localparam int SET_SIZE     = 43;

	localparam logic [8*SET_SIZE-1:0] CHARSET =
		"0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. $/+%";

	localparam logic [9*47-1:0] BARS = {
		9'h114, 9'h148, 9'h144, 9'h142, 9'h128, 9'h124, 9'h122, 9'h150,
		9'h112, 9'h10A, 9'h1A8, 9'h1A4, 9'h1A2, 9'h194, 9'h192, 9'h18A,
		9'h168, 9'h164, 9'h162, 9'h134, 9'h11A, 9'h158, 9'h14C, 9'h146,
		9'h12C, 9'h116, 9'h1B4, 9'h1B2, 9'h1AC, 9'h1A6, 9'h196, 9'h19A,
		9'h16C, 9'h166, 9'h136, 9'h13A, 9'h12E, 9'h1D4, 9'h1D2, 9'h1CA,
		9'h16E, 9'h176, 9'h1AE, 9'h126, 9'h1DA, 9'h1D6, 9'h132
	};

	typedef enum logic [1:0] {
		MSG_IDLE = 2'd0,
		MSG_OPEN = 2'd1,
		MSG_DROP = 2'd2
	} msg_state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic [6:0] len;
	} msg_item_t;

	typedef struct packed {
		logic [8:0] bars;
		logic [3:0] modules;
		err_t       err;
		logic [9:0] width;
		logic       fin;
	} symbol_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [1:0] cmd        = CMD_BEGIN;
	logic [7:0] char_code  = 8'd0;
	logic [6:0] msg_length = 7'd0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [8:0] pattern;
	logic [3:0] bit_count;
	logic [1:0] error_code;
	logic [9:0] total_width;
	logic       last;

	msg_item_t msg_items[$];
	symbol_t   symbols_due[$];

	// encoder state as the block should hold it
	msg_state_t msg_state  = MSG_IDLE;
	logic [5:0] c_sum      = 6'd0;
	logic [5:0] k_sum      = 6'd0;
	logic [4:0] c_wt       = 5'd1;
	logic [3:0] k_wt       = 4'd1;
	logic [6:0] chars_left = 7'd0;
	logic [9:0] width_held = 10'd37;

	logic quiet     = 1'b0;
	logic hold_off  = 1'b0;
	logic stim_done = 1'b0;
	int   send_gap    = 0;
	int   recv_gap    = 0;
	int   items_taken = 0;
	int   failures    = 0;

	code93_barcode_encoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.msg_length (msg_length),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pattern    (pattern),
		.bit_count  (bit_count),
		.error_code (error_code),
		.total_width(total_width),
		.last       (last)
	);

	always #10 clk = ~clk;

	function automatic int char_value(input logic [7:0] ch);
		for (int i = 0; i < SET_SIZE; i++)
			if (CHARSET[8*(SET_SIZE-1-i) +: 8] == ch)
				return i;
		return -1;
	endfunction

	function automatic logic [8:0] bars_of(input int v);
		return BARS[9*(46-v) +: 9];
	endfunction

	function automatic logic [7:0] valid_char();
		return CHARSET[8*$urandom_range(0, SET_SIZE - 1) +: 8];
	endfunction

	function automatic logic [7:0] invalid_char();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(0, 255));
		while (char_value(ch) >= 0);
		return ch;
	endfunction

	function automatic void queue_item(input logic [1:0] op, input logic [7:0] ch,
			input logic [6:0] len);
		msg_items.push_back('{op, ch, len});
	endfunction

	function automatic void emit_symbol(input logic [8:0] bars, input logic [3:0] modules,
			input err_t err, input logic fin);
		symbols_due.push_back('{bars, modules, err, width_held, fin});
	endfunction

	function automatic void drop_message(input err_t err);
		msg_state = MSG_DROP;
		emit_symbol(9'd0, 4'd0, err, 1'b1);
	endfunction

	function automatic void encode_item(input msg_item_t it);
		int v;
		int w;
		int c_val;
		int k_val;
		case (it.op)
			CMD_BEGIN: begin
				// a begin always restarts, even mid-message
				w = 9 * it.len + 37;
				width_held = (w > 1023) ? 10'd1023 : 10'(w);
				c_sum = 6'd0;
				k_sum = 6'd0;
				if (it.len == 0) begin
					c_wt = 5'd1;
					k_wt = 4'd1;
				end else begin
					c_wt = 5'((it.len - 1) % C_SPAN + 1);
					k_wt = 4'(it.len % K_SPAN + 1);
				end
				chars_left = it.len;
				if (it.len > MaxLen)
					drop_message(ERR_MANY);
				else begin
					msg_state = MSG_OPEN;
					emit_symbol(START_STOP, SYM_BITS, ERR_NONE, 1'b0);
				end
			end
			CMD_DATA: if (msg_state == MSG_OPEN) begin
				v = char_value(it.ch);
				// overrun is checked ahead of the character set
				if (chars_left == 0)
					drop_message(ERR_MANY);
				else if (v < 0)
					drop_message(ERR_CHAR);
				else begin
					c_sum = 6'((c_sum + v * c_wt) % MOD_CHECK);
					k_sum = 6'((k_sum + v * k_wt) % MOD_CHECK);
					c_wt = (c_wt <= 1) ? 5'(C_SPAN) : c_wt - 5'd1;
					k_wt = (k_wt <= 1) ? 4'(K_SPAN) : k_wt - 4'd1;
					chars_left = chars_left - 7'd1;
					emit_symbol(bars_of(v), SYM_BITS, ERR_NONE, 1'b0);
				end
			end
			CMD_END: if (msg_state == MSG_OPEN) begin
				if (chars_left != 0)
					drop_message(ERR_FEW);
				else begin
					c_val = c_sum % MOD_CHECK;
					k_val = (k_sum + c_val) % MOD_CHECK;
					emit_symbol(bars_of(c_val), SYM_BITS, ERR_NONE, 1'b0);
					emit_symbol(bars_of(k_val), SYM_BITS, ERR_NONE, 1'b0);
					emit_symbol(START_STOP, SYM_BITS, ERR_NONE, 1'b0);
					emit_symbol(TERM_BAR, TERM_BITS, ERR_NONE, 1'b1);
					msg_state = MSG_IDLE;
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin : drive
		msg_item_t it;
		if (arst_n) begin
			quiet <= msg_items.size() < QUIET_TAIL;
			if (in_valid && !in_stall) begin
				encode_item('{cmd, char_code, msg_length});
				items_taken <= items_taken + 1;
			end
			// a stalled transfer keeps its payload
			if (!(in_valid && in_stall)) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!quiet && !hold_off && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 12);
					in_valid <= 1'b0;
				end else if (msg_items.size() != 0) begin
					it = msg_items.pop_front();
					in_valid <= 1'b1;
					cmd <= it.op;
					char_code <= it.ch;
					msg_length <= it.len;
				end else begin
					in_valid <= 1'b0;
					stim_done <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		symbol_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (symbols_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: unexpected symbol pat=%h bits=%0d err=%0d width=%0d last=%b",
							$realtime, pattern, bit_count, error_code, total_width, last);
				end else begin
					want = symbols_due.pop_front();
					if (pattern !== want.bars || bit_count !== want.modules ||
							error_code !== want.err || total_width !== want.width ||
							last !== want.fin) begin
						failures++;
						if (failures <= 10) begin
							$write("%0t: symbol mismatch: want pat=%h bits=%0d err=%0d ",
								$realtime, want.bars, want.modules, want.err);
							$write("width=%0d last=%b, ", want.width, want.fin);
							$display("got pat=%h bits=%0d err=%0d width=%0d last=%b",
								pattern, bit_count, error_code, total_width, last);
						end
					end
				end
			end
			if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(0, 12);
				out_stall <= 1'b1;
			end else
				out_stall <= hold_off;
		end
	end

	// long receiver hold-off while the sender keeps pushing, to back up the job queue
	initial begin : long_hold
		while (items_taken < HOLD_AFTER)
			@(negedge clk);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : watchdog
		#5_000_000;
		$display("** code93_barcode_encoder: FAILED **");
		$finish;
	end

	initial begin : run
		int counted;
		int roll;
		int r;
		int len;
		int n;
		int fault;
		int bad_at;

		// nothing open yet: data, end and the unused command are all ignored
		queue_item(CMD_DATA, "A", 7'd0);
		queue_item(CMD_END, 8'd0, 7'd0);
		queue_item(CMD_NOP, 8'd0, 7'd0);
		// empty message, then an overrun on an empty message
		queue_item(CMD_BEGIN, 8'd0, 7'd0);
		queue_item(CMD_END, 8'd0, 7'd0);
		queue_item(CMD_BEGIN, 8'd0, 7'd0);
		queue_item(CMD_DATA, "1", 7'd0);
		// first and last character values, unused command mid-message
		queue_item(CMD_BEGIN, 8'd0, 7'd3);
		queue_item(CMD_DATA, "0", 7'd0);
		queue_item(CMD_NOP, 8'hFF, 7'h7F);
		queue_item(CMD_DATA, "%", 7'd0);
		queue_item(CMD_DATA, "Z", 7'd0);
		queue_item(CMD_END, 8'd0, 7'd0);
		// lower case rejected, rest dropped
		queue_item(CMD_BEGIN, 8'd0, 7'd2);
		queue_item(CMD_DATA, "a", 7'd0);
		queue_item(CMD_END, 8'd0, 7'd0);
		queue_item(CMD_BEGIN, 8'd0, 7'd1);
		queue_item(CMD_DATA, 8'hFF, 7'd0);
		// end arrives early
		queue_item(CMD_BEGIN, 8'd0, 7'd2);
		queue_item(CMD_DATA, "A", 7'd0);
		queue_item(CMD_END, 8'd0, 7'd0);
		// length just over the limit, and the largest one (width saturates)
		queue_item(CMD_BEGIN, 8'd0, 7'(MaxLen + 1));
		queue_item(CMD_BEGIN, 8'd0, 7'h7F);
		// restart mid-message
		queue_item(CMD_BEGIN, 8'd0, 7'd2);
		queue_item(CMD_DATA, "B", 7'd0);
		queue_item(CMD_BEGIN, 8'd0, 7'd1);
		queue_item(CMD_DATA, "$", 7'd0);
		queue_item(CMD_END, 8'd0, 7'd0);

		counted = 0;
		while (counted < TARGET_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 6)
				queue_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
					7'($urandom_range(0, 127)));
			else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(0, 8);
				else if (r < 90)
					len = $urandom_range(9, 30);
				else if (r < 96)
					len = $urandom_range(31, MaxLen);
				else
					len = $urandom_range(MaxLen + 1, 127);
				queue_item(CMD_BEGIN, 8'($urandom_range(0, 255)), 7'(len));
				counted++;
				if (len <= MaxLen) begin
					// 0-7 bad char, 8-14 early end, 15-21 abandoned, 22-27 one char too many
					fault = $urandom_range(0, 99);
					n = len;
					if (fault >= 8 && fault < 22 && len > 0)
						n = $urandom_range(0, len - 1);
					bad_at = (fault < 8 && n > 0) ? $urandom_range(0, n - 1) : -1;
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 39) == 0)
							queue_item(CMD_NOP, 8'($urandom_range(0, 255)),
								7'($urandom_range(0, 127)));
						queue_item(CMD_DATA, (i == bad_at) ? invalid_char() : valid_char(),
							7'($urandom_range(0, 127)));
						counted++;
					end
					if (fault >= 22 && fault < 28) begin
						queue_item(CMD_DATA, valid_char(), 7'($urandom_range(0, 127)));
						counted++;
					end
					if (fault < 15 || fault >= 22) begin
						queue_item(CMD_END, 8'($urandom_range(0, 255)),
							7'($urandom_range(0, 127)));
						counted++;
					end
				end
			end
		end

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		while (!stim_done || symbols_due.size() != 0)
			@(negedge clk);
		repeat (20)
			@(negedge clk);
		if (symbols_due.size() != 0) begin
			failures++;
			$display("%0d expected symbols never arrived", symbols_due.size());
		end
		if (failures == 0)
			$display("** code93_barcode_encoder: PASSED **");
		else
			$display("** code93_barcode_encoder: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
sv/c93_pkg.sv
sv/c93_front.sv
sv/c93_fifo.sv
sv/c93_back.sv
sv/code93_barcode_encoder.sv
dv/testbench.sv
